// ----- sv/tlb_page_translation_core_defines.svh -----
// Assertion macros shared by the translation core RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef TLB_PAGE_TRANSLATION_CORE_DEFINES_SVH
`define TLB_PAGE_TRANSLATION_CORE_DEFINES_SVH
`ifndef SYNTH
// Antecedent and consequent hold in the same cycle.
`define TLBPT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlbpt assertion failed");
// Consequent holds in the cycle after the antecedent.
`define TLBPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlbpt assertion failed");
`else
`define TLBPT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TLBPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/tlbpt_pkg.sv -----
// Package for the TLB page translation core: sizes, widths and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package tlbpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int FRAME_COUNT = 256;
  localparam int PAGE_BYTES  = 256;

  localparam int ADDR_W  = 16;
  localparam int OFFS_W  = $clog2(PAGE_BYTES);
  localparam int PAGE_W  = ADDR_W - OFFS_W;
  localparam int FRAME_W = 8;
  localparam int TLB_IW  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int TLB_CW  = $clog2(TLB_ENTRIES + 1);
  localparam int FT_AW   = $clog2(FRAME_COUNT);
  localparam int FT_CW   = FT_AW + 1;

  typedef struct packed {
    logic load;
    logic tlb_step;
    logic tlb_hit;
    logic ft_step;
    logic ft_found;
    logic ft_fault;
    logic out_load;
  } tlbpt_cmd_t;

  typedef struct packed {
    logic tlb_end;
    logic tlb_match;
    logic ft_match;
    logic ft_last;
    logic out_busy;
  } tlbpt_sts_t;

endpackage

// ----- sv/tlbpt_ctrl.sv -----
// Sequencing state machine of the translation core.
// Depends on tlbpt_pkg; drives the datapath through tlbpt_cmd_t.
`timescale 1ns / 1ps
module tlbpt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tlbpt_pkg::tlbpt_sts_t sts_i,
  output tlbpt_pkg::tlbpt_cmd_t cmd_o
);
  import tlbpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TLB  = 4'b0010,
    S_FT   = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TLB;
        end
      end
      S_TLB: begin
        if (sts_i.tlb_end) begin
          state_d = S_FT;
        end else if (sts_i.tlb_match) begin
          cmd_o.tlb_hit = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.tlb_step = 1'b1;
        end
      end
      S_FT: begin
        cmd_o.ft_step = 1'b1;
        if (sts_i.ft_match) begin
          cmd_o.ft_found = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.ft_last) begin
          cmd_o.ft_fault = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ----- sv/tlbpt_dp.sv -----
// Datapath of the translation core: TLB registers, frame table memory,
// scan counters, result and output registers. Depends on tlbpt_pkg.
`timescale 1ns / 1ps
module tlbpt_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tlbpt_pkg::tlbpt_cmd_t     cmd_i,
  output tlbpt_pkg::tlbpt_sts_t     sts_o,
  input  logic [tlbpt_pkg::ADDR_W-1:0]  logical_address_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [tlbpt_pkg::ADDR_W-1:0]  physical_address_o,
  output logic [tlbpt_pkg::FRAME_W-1:0] frame_number_o,
  output logic                      tlb_hit_o,
  output logic                      page_fault_o
);
  import tlbpt_pkg::*;

  localparam logic [FT_CW-1:0] FtEnd  = FT_CW'(FRAME_COUNT);
  localparam logic [FT_AW-1:0] FtLast = FT_AW'(FRAME_COUNT - 1);
  localparam logic [TLB_CW-1:0] TlbFull = TLB_CW'(TLB_ENTRIES);

  logic [ADDR_W-1:0]  addr_q;
  logic [PAGE_W-1:0]  page;

  logic [PAGE_W-1:0]  tlb_page_q  [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_frame_q [TLB_ENTRIES];
  logic [TLB_CW-1:0]  tlb_used_q;
  logic [TLB_CW-1:0]  tidx_q;
  logic [TLB_IW-1:0]  tsel;

  logic [PAGE_W-1:0]  ft_page_mem [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] ft_valid_q;
  logic [FT_AW-1:0]   next_free_q;
  logic [FT_CW-1:0]   ft_cnt_q;
  logic               rd_en;
  logic               rd_pend_q;
  logic [PAGE_W-1:0]  rd_page_q;
  logic               rd_valid_q;
  logic [FT_AW-1:0]   rd_idx_q;

  logic               ins;
  logic               rm;
  logic [TLB_CW-1:0]  rm_pos;
  logic [TLB_CW-1:0]  wr_idx;
  logic [FRAME_W-1:0] new_frame;

  logic [FRAME_W-1:0] res_frame_q;
  logic               res_hit_q;
  logic               res_fault_q;

  logic               out_valid_q;
  logic [ADDR_W-1:0]  out_paddr_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic               out_hit_q;
  logic               out_fault_q;

  assign page = addr_q[ADDR_W-1:OFFS_W];
  assign tsel = tidx_q[TLB_IW-1:0];

  // Status toward the controller.
  assign sts_o.tlb_end   = (tidx_q == tlb_used_q);
  assign sts_o.tlb_match = (tidx_q != tlb_used_q) && (tlb_page_q[tsel] == page);
  assign sts_o.ft_match  = rd_pend_q && rd_valid_q && (rd_page_q == page);
  assign sts_o.ft_last   = rd_pend_q && (rd_idx_q == FtLast);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign rd_en = cmd_i.ft_step && (ft_cnt_q < FtEnd);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= logical_address_i;
    end
  end

  // Scan counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tidx_q    <= '0;
      ft_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
    end else if (cmd_i.load) begin
      tidx_q    <= '0;
      ft_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      if (cmd_i.tlb_step) begin
        tidx_q <= tidx_q + 1'b1;
      end
      if (rd_en) begin
        ft_cnt_q <= ft_cnt_q + 1'b1;
      end
      rd_pend_q <= rd_en;
    end
  end

  // Frame table: one registered read port, one write port for faults.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_page_q  <= ft_page_mem[ft_cnt_q[FT_AW-1:0]];
      rd_valid_q <= ft_valid_q[ft_cnt_q[FT_AW-1:0]];
      rd_idx_q   <= ft_cnt_q[FT_AW-1:0];
    end
    if (cmd_i.ft_fault) begin
      ft_page_mem[next_free_q] <= page;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_valid_q  <= '0;
      next_free_q <= '0;
    end else if (cmd_i.ft_fault) begin
      ft_valid_q[next_free_q] <= 1'b1;
      next_free_q <= (next_free_q == FtLast) ? '0 : next_free_q + 1'b1;
    end
  end

  // TLB insert: a hit removes its own entry, a full TLB drops the oldest,
  // then the mapping lands at the most-recent end.
  assign ins    = cmd_i.tlb_hit || cmd_i.ft_found || cmd_i.ft_fault;
  assign rm     = cmd_i.tlb_hit || (tlb_used_q == TlbFull);
  assign rm_pos = cmd_i.tlb_hit ? tidx_q : '0;
  assign wr_idx = rm ? tlb_used_q - 1'b1 : tlb_used_q;

  always_comb begin
    if (cmd_i.tlb_hit) begin
      new_frame = tlb_frame_q[tsel];
    end else if (cmd_i.ft_found) begin
      new_frame = FRAME_W'(rd_idx_q);
    end else begin
      new_frame = FRAME_W'(next_free_q);
    end
  end

  for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_tlb
    always_ff @(posedge clk_i) begin
      if (ins) begin
        if (TLB_CW'(g) == wr_idx) begin
          tlb_page_q[g]  <= page;
          tlb_frame_q[g] <= new_frame;
        end else if (rm && (TLB_CW'(g) >= rm_pos) && (TLB_CW'(g) < wr_idx)) begin
          tlb_page_q[g]  <= tlb_page_q[(g + 1) % TLB_ENTRIES];
          tlb_frame_q[g] <= tlb_frame_q[(g + 1) % TLB_ENTRIES];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_used_q <= '0;
    end else if (ins && !rm) begin
      tlb_used_q <= tlb_used_q + 1'b1;
    end
  end

  // Result of the current transaction.
  always_ff @(posedge clk_i) begin
    if (ins) begin
      res_frame_q <= new_frame;
      res_hit_q   <= cmd_i.tlb_hit;
      res_fault_q <= cmd_i.ft_fault;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_paddr_q <= {res_frame_q, addr_q[OFFS_W-1:0]};
      out_frame_q <= res_frame_q;
      out_hit_q   <= res_hit_q;
      out_fault_q <= res_fault_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = out_paddr_q;
  assign frame_number_o     = out_frame_q;
  assign tlb_hit_o          = out_hit_q;
  assign page_fault_o       = out_fault_q;

endmodule

// ----- sv/tlb_page_translation_core.sv -----
// Top level of the TLB page translation core.
// Depends on tlbpt_pkg, tlbpt_ctrl, tlbpt_dp and the assertion macro header.
//
// Usage: one input channel (in_valid_i/in_ready_o, logical_address_i) and one
// output channel (out_valid_o/out_ready_i with physical_address_o,
// frame_number_o, tlb_hit_o and page_fault_o). Each input transaction yields
// exactly one output transaction, in order.
// The block works on one address at a time. After acceptance it walks the
// filled TLB entries, at most 16, one per cycle. A hit finishes right there. On a miss it
// streams the 256-entry frame table through its registered read port, one
// entry per cycle, stopping at the first valid match or taking a page fault
// after the last entry. The result then moves into the output register.
// The time from acceptance to out_valid_o grows with the TLB position of a
// hit and, on a frame table hit, with the TLB fill and the frame index; a
// page fault with a full TLB walks every TLB entry and every frame.
// The next address is accepted in the cycle after the result is loaded, even
// while that result still waits on out_ready_i. A stalled receiver only holds
// the following result back in its final state.
// Reset empties the TLB, marks every frame unmapped and restarts the
// round-robin frame pointer at zero; no clearing pass is needed.
`timescale 1ns / 1ps
`include "tlb_page_translation_core_defines.svh"
module tlb_page_translation_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tlbpt_pkg::ADDR_W-1:0]  logical_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tlbpt_pkg::ADDR_W-1:0]  physical_address_o,
  output logic [tlbpt_pkg::FRAME_W-1:0] frame_number_o,
  output logic                          tlb_hit_o,
  output logic                          page_fault_o
);
  import tlbpt_pkg::*;

  tlbpt_cmd_t cmd;
  tlbpt_sts_t sts;

  // The controller sequences the TLB walk, frame table scan and output load.
  tlbpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds all translation state and the output register.
  tlbpt_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .logical_address_i  (logical_address_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .physical_address_o (physical_address_o),
    .frame_number_o     (frame_number_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o)
  );

  // A transaction is worked on alone, so the input closes right after it.
  `TLBPT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // No two outcomes are signalled in the same cycle.
  `TLBPT_ASSERT_IMPLIES(a_one_outcome, clk_i, rst_ni, 1'b1,
                        $onehot0({cmd.tlb_hit, cmd.ft_found, cmd.ft_fault}))
  // A TLB hit is never taken past the filled entries.
  `TLBPT_ASSERT_IMPLIES(a_hit_in_range, clk_i, rst_ni, cmd.tlb_hit, !sts.tlb_end)
  // A fault only follows a scan that reached the last frame.
  `TLBPT_ASSERT_IMPLIES(a_fault_after_scan, clk_i, rst_ni, cmd.ft_fault, sts.ft_last)
  // The output register is never overwritten while its result is stalled.
  `TLBPT_ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, cmd.out_load,
                        !(out_valid_o && !out_ready_i))

endmodule

// ----- verif/tlb_page_translation_checker.sv -----
// Checker for the TLB page translation core. It watches both channels, predicts the result of
// each address and compares it with what the core returns.
// Depends on tlbpt_pkg for the address, page and frame widths and the table sizes.
`timescale 1ns / 1ps
module tlb_page_translation_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [tlbpt_pkg::ADDR_W-1:0]  logical_address_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [tlbpt_pkg::ADDR_W-1:0]  physical_address_i,
  input  logic [tlbpt_pkg::FRAME_W-1:0] frame_number_i,
  input  logic                          tlb_hit_i,
  input  logic                          page_fault_i,
  output int                            error_count_o,
  output int                            pending_o
);
  import tlbpt_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  phys;
    logic [FRAME_W-1:0] frame;
    logic               hit;
    logic               fault;
  } xlate_t;

  // Shadow copy of the TLB (oldest entry at index 0) and of the frame table.
  logic [PAGE_W-1:0]  shadow_tlb_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0] shadow_tlb_frame [TLB_ENTRIES];
  int                 shadow_tlb_count;
  logic [PAGE_W-1:0]  frame_owner      [FRAME_COUNT];
  logic               frame_mapped     [FRAME_COUNT];
  logic [FRAME_W-1:0] victim_frame;

  xlate_t expected_xlates[$];
  int     mismatches;

  function automatic void tlb_drop(input int pos);
    for (int k = pos; k + 1 < shadow_tlb_count; k++) begin
      shadow_tlb_page[k]  = shadow_tlb_page[k+1];
      shadow_tlb_frame[k] = shadow_tlb_frame[k+1];
    end
    shadow_tlb_count--;
  endfunction

  function automatic void tlb_insert(input logic [PAGE_W-1:0] page,
                                     input logic [FRAME_W-1:0] frame);
    if (shadow_tlb_count >= TLB_ENTRIES) begin
      tlb_drop(0);
    end
    shadow_tlb_page[shadow_tlb_count]  = page;
    shadow_tlb_frame[shadow_tlb_count] = frame;
    shadow_tlb_count++;
  endfunction

  function automatic xlate_t translate_address(input logic [ADDR_W-1:0] addr);
    logic [PAGE_W-1:0]  page;
    logic [OFFS_W-1:0]  offset;
    logic [FRAME_W-1:0] frame;
    logic               found;
    xlate_t             res;
    page      = addr[ADDR_W-1:OFFS_W];
    offset    = addr[OFFS_W-1:0];
    frame     = '0;
    found     = 1'b0;
    res.addr  = addr;
    res.hit   = 1'b0;
    res.fault = 1'b0;
    for (int k = 0; k < shadow_tlb_count; k++) begin
      if (!res.hit && shadow_tlb_page[k] == page) begin
        res.hit = 1'b1;
        frame   = shadow_tlb_frame[k];
        tlb_drop(k);
        tlb_insert(page, frame);
      end
    end
    if (!res.hit) begin
      // Lowest mapped frame that holds the page wins.
      for (int f = 0; f < FRAME_COUNT; f++) begin
        if (!found && frame_mapped[f] && frame_owner[f] == page) begin
          found = 1'b1;
          frame = FRAME_W'(f);
        end
      end
      if (!found) begin
        res.fault                  = 1'b1;
        frame                      = victim_frame;
        frame_owner[victim_frame]  = page;
        frame_mapped[victim_frame] = 1'b1;
        victim_frame               = FRAME_W'((int'(victim_frame) + 1) % FRAME_COUNT);
      end
      tlb_insert(page, frame);
    end
    res.frame = frame;
    res.phys  = ADDR_W'(int'(frame) * PAGE_BYTES + int'(offset));
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    xlate_t want;
    if (!rst_ni) begin
      shadow_tlb_count = 0;
      victim_frame     = '0;
      for (int f = 0; f < FRAME_COUNT; f++) begin
        frame_mapped[f] = 1'b0;
      end
      expected_xlates.delete();
      mismatches    = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_xlates.insert(expected_xlates.size(), translate_address(logical_address_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_xlates.size() == 0) begin
          if (mismatches < 10) begin
            $display("checker: unexpected result phys %h frame %h hit %b fault %b",
                     physical_address_i, frame_number_i, tlb_hit_i, page_fault_i);
          end
          mismatches++;
        end else begin
          want = expected_xlates.pop_front();
          if (physical_address_i !== want.phys || frame_number_i !== want.frame ||
              tlb_hit_i !== want.hit || page_fault_i !== want.fault) begin
            if (mismatches < 10) begin
              $display("checker: addr %h expected phys %h frame %h hit %b fault %b",
                       want.addr, want.phys, want.frame, want.hit, want.fault);
              $display("checker:            got phys %h frame %h hit %b fault %b",
                       physical_address_i, frame_number_i, tlb_hit_i, page_fault_i);
            end
            mismatches++;
          end
        end
      end
      error_count_o <= mismatches;
      pending_o     <= expected_xlates.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the TLB page translation testbench: clock, reset, address stimulus, receiver stalls
// and the verdict. Depends on tlbpt_pkg, tlb_page_translation_core and the checker module.
`timescale 1ns / 1ps
module testbench;
  import tlbpt_pkg::*;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic               in_ready_o;
  logic [ADDR_W-1:0]  logical_address_i = '0;
  logic               out_valid_o;
  logic               out_ready_i       = 1'b0;
  logic [ADDR_W-1:0]  physical_address_o;
  logic [FRAME_W-1:0] frame_number_o;
  logic               tlb_hit_o;
  logic               page_fault_o;

  int  error_count;
  int  pending;

  // When set, the sender or the receiver runs without gaps for a stretch.
  logic steady_in  = 1'b0;
  logic steady_out = 1'b0;

  // Pages most recently sent, newest last; picking from these mostly yields TLB hits.
  logic [PAGE_W-1:0] recent_pages[$];
  // Pages not yet picked as new ones; picking from these mostly yields page faults.
  logic [PAGE_W-1:0] fresh_pages[$];

  tlb_page_translation_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .logical_address_i  (logical_address_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .physical_address_o (physical_address_o),
    .frame_number_o     (frame_number_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o)
  );

  tlb_page_translation_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .logical_address_i  (logical_address_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .physical_address_i (physical_address_o),
    .frame_number_i     (frame_number_o),
    .tlb_hit_i          (tlb_hit_o),
    .page_fault_i       (page_fault_o),
    .error_count_o      (error_count),
    .pending_o          (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length shared by both sides: mostly none or a few cycles, now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // Called and returning at a falling edge. The valid line is lowered only when a gap
  // is inserted, so back-to-back transactions keep it high without a glitch.
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    int gap;
    gap = steady_in ? 0 : gap_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    logical_address_i <= addr;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Sends a page with a random offset and keeps the list of recent pages up to date.
  task automatic send_page(input logic [PAGE_W-1:0] page);
    for (int k = recent_pages.size() - 1; k >= 0; k--) begin
      if (recent_pages[k] == page) begin
        recent_pages.delete(k);
      end
    end
    recent_pages.insert(recent_pages.size(), page);
    if (recent_pages.size() > TLB_ENTRIES) begin
      void'(recent_pages.pop_front());
    end
    send_address({page, OFFS_W'($urandom_range(0, PAGE_BYTES - 1))});
  endtask

  // Receiver: stalls of random length, with stretches that never stall.
  initial begin
    int stall;
    int cycles;
    stall  = 0;
    cycles = 0;
    forever begin
      @(negedge clk_i);
      cycles++;
      if (cycles % 500 == 0) begin
        steady_out <= ($urandom_range(0, 3) == 0);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady_out && $urandom_range(0, 99) < 30) begin
          stall = gap_length();
        end
      end
    end
  end

  initial begin
    int                choice;
    int                idx;
    logic [PAGE_W-1:0] page;
    for (int p = 0; p < FRAME_COUNT; p++) begin
      fresh_pages.insert(fresh_pages.size(), PAGE_W'(p));
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. The lowest and highest pages and offsets, a fault followed by a hit on
    // the newest entry, and a hit on the oldest entry, which moves it to the recent end.
    send_address(16'h0000);
    send_address(16'h00FF);
    send_address(16'hFFFF);
    send_address(16'hFF00);
    send_address(16'h0000);
    // Sixteen new pages fill the TLB and push out pages 0xFF and 0x00, so the full-TLB
    // insert drops its oldest entry for the last two of them.
    for (int p = 1; p <= TLB_ENTRIES; p++) begin
      send_address({PAGE_W'(p), (p % 2 == 1) ? 8'hAA : 8'h55});
    end
    // Both evicted pages are now found only by the frame table scan, frame 0 and frame 1.
    send_address(16'h0080);
    send_address(16'hFF7F);

    // Random part: new pages, recently used pages and arbitrary pages. With as many pages as
    // frames, the round-robin pointer wraps only after every page has faulted in once.
    for (int n = 0; n < 500; n++) begin
      if (n % 40 == 0) begin
        steady_in <= ($urandom_range(0, 3) == 0);
      end
      choice = $urandom_range(0, 99);
      if (fresh_pages.size() > 0 && choice < 55) begin
        idx  = $urandom_range(0, fresh_pages.size() - 1);
        page = fresh_pages[idx];
        fresh_pages.delete(idx);
      end else if (recent_pages.size() > 0 && choice < 85) begin
        page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
      end else begin
        page = PAGE_W'($urandom_range(0, FRAME_COUNT - 1));
      end
      send_page(page);
    end
    // Whatever pages were never picked are sent now; the unmapped ones fault in, so the frame pointer wraps.
    while (fresh_pages.size() > 0) begin
      send_page(fresh_pages.pop_front());
    end
    in_valid_i <= 1'b0;

    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (300) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // The slowest clean run is well under a quarter of this.
  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
